// ===== design/sliding_window_max_macros.svh =====
// ----------------------------------------------------------------------------
// Sliding window maximum assertion macros
// Shared property shapes for the checker of the sliding window maximum block.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAX_MACROS_SVH
`define SLIDING_WINDOW_MAX_MACROS_SVH

// Overlapping implication, disabled while reset is high.
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define SWM_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window maximum package
// Widths, sizes and shared types of the sliding window maximum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swm_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int SAMPLE_W   = 32;
  localparam int WIN_W      = $clog2(MAX_WINDOW) + 1;
  localparam int TAP_W      = $clog2(MAX_WINDOW);
  localparam int POS_W      = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Control handed from the top level to the cell chain.
  typedef struct packed {
    logic             shift;
    logic [TAP_W-1:0] tap;
  } chain_ctrl_t;

endpackage

// ===== design/sliding_window_max.sv =====
// ----------------------------------------------------------------------------
// Sliding window maximum
// Running maximum of the last window_size signed samples, built as a chain
// of running-maximum cells with a two-word result queue.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_valid/cfg_ready   window_size
// in        in         in_valid/in_ready     sample, last_in
// out       out        out_valid/out_ready   window_max, last_out
//
// One sample is taken per cycle while in_ready is high; every cell updates from
// its neighbor in the same cycle, and the result word is registered on acceptance.
// Reset clears the counters and the result queue; cell contents are not
// cleared, since only cells refilled in the current sequence are tapped.
// The result queue holds two words, so a stalled output does not hold up the
// input until both words are waiting; in_ready drops only then.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_max (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [swm_pkg::WIN_W-1:0] window_size,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  swm_pkg::sample_t      sample,
  input  logic                  last_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output swm_pkg::sample_t      window_max,
  output logic                  last_out
);
  import swm_pkg::*;

  logic [WIN_W-1:0] win_reg;
  logic [WIN_W-1:0] win_eff;
  logic [WIN_W-1:0] win_m1;
  logic [POS_W-1:0] pos;
  logic [WIN_W-1:0] live;
  logic [WIN_W-1:0] live_inc;
  logic [WIN_W-1:0] live_next;
  logic [WIN_W-1:0] tap_full;
  logic             accept;
  logic             emit;
  logic             push;
  logic             pop;
  chain_ctrl_t      ctrl;
  sample_t          tap_value;
  sample_t          result;
  logic [1:0]       count;
  sample_t          q0_max;
  logic             q0_last;
  sample_t          q1_max;
  logic             q1_last;

  assign cfg_ready = !rst;
  assign in_ready  = !rst && (count != 2'd2);
  assign accept    = in_valid && in_ready;

  always_comb begin
    if (win_reg == '0) begin
      win_eff = WIN_W'(1);
    end else if (win_reg > WIN_W'(MAX_WINDOW)) begin
      win_eff = WIN_W'(MAX_WINDOW);
    end else begin
      win_eff = win_reg;
    end
  end

  assign win_m1 = win_eff - WIN_W'(1);

  // Candidates that survive all expiry checks are always the newest ones, so
  // their number is enough: it grows by one per sample and is capped by the
  // window in force for this sample.
  assign live_inc  = live + WIN_W'(1);
  assign live_next = (live_inc > win_eff) ? win_eff : live_inc;
  assign tap_full  = live_next - WIN_W'(2);

  assign ctrl = {accept, tap_full[TAP_W-1:0]};

  swm_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .sample    (sample),
    .tap_value (tap_value)
  );

  always_comb begin
    if (live_next == WIN_W'(1)) begin
      result = sample;
    end else begin
      result = (sample > tap_value) ? sample : tap_value;
    end
  end

  assign emit = (pos >= POS_W'(win_m1));
  assign push = accept && emit;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_reg <= WIN_W'(1);
      pos     <= '0;
      live    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        win_reg <= window_size;
      end
      if (accept) begin
        pos  <= last_in ? '0 : pos + POS_W'(1);
        live <= last_in ? '0 : live_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        q0_max  <= q1_max;
        q0_last <= q1_last;
        if (push) begin
          q1_max  <= result;
          q1_last <= last_in;
        end
      end else if (push) begin
        q0_max  <= result;
        q0_last <= last_in;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        q0_max  <= result;
        q0_last <= last_in;
      end else begin
        q1_max  <= result;
        q1_last <= last_in;
      end
    end
  end

  assign out_valid  = (count != 2'd0);
  assign window_max = q0_max;
  assign last_out   = q0_last;

endmodule

// ===== design/swm_cell.sv =====
// ----------------------------------------------------------------------------
// Running maximum cell
// Holds the maximum of the most recent k+1 samples, where k is its place in
// the chain, built from its left neighbor and the new sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_cell (
  input  logic             clk,
  input  logic             shift,
  input  swm_pkg::sample_t sample,
  input  swm_pkg::sample_t nbr,
  output swm_pkg::sample_t held
);
  import swm_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= (sample > nbr) ? sample : nbr;
    end
  end

endmodule

// ===== design/swm_chain.sv =====
// ----------------------------------------------------------------------------
// Running maximum chain
// A row of cells; cell k ends each update holding the maximum of the last
// k+1 samples. One cell is tapped for the result path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_chain (
  input  logic                 clk,
  input  swm_pkg::chain_ctrl_t ctrl,
  input  swm_pkg::sample_t     sample,
  output swm_pkg::sample_t     tap_value
);
  import swm_pkg::*;

  sample_t held [MAX_WINDOW];

  // The first cell sees the sample itself as its neighbor, so it just loads it.
  swm_cell u_cell0 (
    .clk    (clk),
    .shift  (ctrl.shift),
    .sample (sample),
    .nbr    (sample),
    .held   (held[0])
  );

  for (genvar k = 1; k < MAX_WINDOW; k++) begin : g_cell
    swm_cell u_cell (
      .clk    (clk),
      .shift  (ctrl.shift),
      .sample (sample),
      .nbr    (held[k-1]),
      .held   (held[k])
    );
  end

  assign tap_value = held[ctrl.tap];

endmodule

// ===== design/swm_checker.sv =====
// ----------------------------------------------------------------------------
// Sliding window maximum checker
// Port-level properties of the sliding window maximum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_max_macros.svh"

module swm_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input swm_pkg::sample_t window_max,
  input logic             last_out
);
  import swm_pkg::*;

  `SWM_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid, "result word present after reset")
  `SWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(window_max) && $stable(last_out), "stalled result word changed")
  `SWM_ASSERT_NOW(a_backpressure, !in_ready, out_valid, "input stalled with no result word waiting")
  `SWM_ASSERT_NOW(a_no_spurious, $rose(out_valid), $past(in_valid && in_ready), "result word without an accepted sample")

endmodule

bind sliding_window_max swm_checker u_swm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .window_max (window_max),
  .last_out   (last_out)
);

// ===== tb/sv/window_max_checker.sv =====
// ----------------------------------------------------------------------------
// Sliding window maximum checker
// Watches the configuration, input and output channels of the block, keeps
// its own deque of candidate samples to work out each window maximum, and
// compares every result word with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module window_max_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [swm_pkg::WIN_W-1:0] window_size,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  swm_pkg::sample_t          sample,
  input  logic                      last_in,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  swm_pkg::sample_t          window_max,
  input  logic                      last_out,
  output int                        fail_count,
  output int                        pending
);
  import swm_pkg::*;

  typedef struct {
    sample_t peak;
    logic    last;
  } peak_t;

  peak_t       expected_peaks[$];
  sample_t     cand_val[MAX_WINDOW];
  logic [31:0] cand_pos[MAX_WINDOW];
  int unsigned head;
  int unsigned tail;
  int unsigned live;
  logic [31:0] seq_pos;
  logic [WIN_W-1:0] win_reg;
  int          errors = 0;

  function automatic void clear_sequence();
    head    = 0;
    tail    = 0;
    live    = 0;
    seq_pos = '0;
  endfunction

  // Runs one sample through the candidate deque and queues the maximum it
  // produces, if the window is full by now.
  function automatic void advance_deque(sample_t s, logic l);
    logic [31:0] span;
    logic [31:0] age;
    int unsigned rear;
    peak_t       p;
    if (win_reg == 0) span = 1;
    else if (win_reg > MAX_WINDOW) span = MAX_WINDOW;
    else span = 32'(win_reg);

    while (live > 0) begin
      age = seq_pos - cand_pos[head];
      if (age < span) break;
      head = (head + 1) % MAX_WINDOW;
      live--;
    end

    // Equal samples stay; only strictly smaller ones are pushed out.
    while (live > 0) begin
      rear = (tail + MAX_WINDOW - 1) % MAX_WINDOW;
      if (cand_val[rear] < s) begin
        tail = rear;
        live--;
      end else begin
        break;
      end
    end

    if (live < MAX_WINDOW) begin
      cand_val[tail] = s;
      cand_pos[tail] = seq_pos;
      tail = (tail + 1) % MAX_WINDOW;
      live++;
    end

    if (seq_pos >= span - 1) begin
      p.peak = cand_val[head];
      p.last = l;
      expected_peaks.push_back(p);
    end

    seq_pos = seq_pos + 1;
    if (l) clear_sequence();
  endfunction

  always @(posedge clk) begin
    peak_t p;
    if (rst) begin
      clear_sequence();
      win_reg = 1;
      expected_peaks.delete();
    end else begin
      // A sample accepted at the same edge as a write still sees the old size.
      if (in_valid && in_ready) advance_deque(sample, last_in);
      if (cfg_valid && cfg_ready) win_reg = window_size;
      if (out_valid && out_ready) begin
        if (expected_peaks.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual window_max %0d last_out %0b",
                   $time, window_max, last_out);
          errors++;
        end else begin
          p = expected_peaks.pop_front();
          if (window_max !== p.peak) begin
            $display("%0t: window_max mismatch: expected %0d, actual %0d",
                     $time, p.peak, window_max);
            errors++;
          end
          if (last_out !== p.last) begin
            $display("%0t: last_out mismatch: expected %0b, actual %0b",
                     $time, p.last, last_out);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_peaks.size();
  end

endmodule

// ===== tb/sv/tb_sliding_window_max.sv =====
// ----------------------------------------------------------------------------
// Sliding window maximum testbench
// Drives windowed sample sequences through the block under random idling on
// both channels, rewrites the window size between phases and lets the
// checker judge every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sliding_window_max;
  import swm_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int ITEM_TARGET = 1450;
  localparam int CALM_POINT  = 1250;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {MIX_FULL, MIX_NARROW, MIX_EXTREME, MIX_RISING, MIX_FALLING} sample_mix_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [WIN_W-1:0] window_size = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  sample_t          sample = '0;
  logic             last_in = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  sample_t          window_max;
  logic             last_out;
  int               fail_count;
  int               pending;

  bit          calm = 1'b0;
  bit          gaps_on = 1'b0;
  int          hold_reqs = 0;
  int          sent = 0;
  int          cycle_count = 0;
  int          cur_win = 1;
  int          seq_left = 0;
  sample_mix_t seq_mix = MIX_FULL;
  sample_t     prev_sample = '0;

  int  hold_seen = 0;
  int  hold_left = 0;
  int  rx_burst = 0;
  bit  rx_stall = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sliding_window_max DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .window_size(window_size),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .last_in    (last_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .window_max (window_max),
    .last_out   (last_out)
  );

  window_max_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .window_size(window_size),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .last_in    (last_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .window_max (window_max),
    .last_out   (last_out),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random ready and stall bursts, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_burst == 0) begin
        rx_stall = ($urandom_range(0, 2) == 0);
        rx_burst = rx_stall ? $urandom_range(1, 12) : $urandom_range(1, 40);
      end
      rx_burst--;
      out_ready <= !rx_stall;
    end
  end

  task automatic push_word(sample_t s, logic l);
    if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    last_in  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Waits until every predicted word is back and the pipeline has drained,
  // since sequences that end short leave no word to wait for.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window(logic [WIN_W-1:0] w);
    cfg_valid   <= 1'b1;
    window_size <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (w == 0) cur_win = 1;
    else if (w > MAX_WINDOW) cur_win = MAX_WINDOW;
    else cur_win = w;
  endtask

  function automatic sample_t pick_sample(sample_mix_t mix);
    sample_t s;
    if ($urandom_range(0, 7) == 0) mix = MIX_FULL;
    case (mix)
      MIX_NARROW: s = sample_t'($urandom_range(0, 6)) - sample_t'(3);
      MIX_EXTREME: begin
        case ($urandom_range(0, 3))
          0: s = sample_t'(32'h8000_0000);
          1: s = sample_t'(32'h7FFF_FFFF);
          2: s = '0;
          default: s = '1;
        endcase
      end
      MIX_RISING:  s = prev_sample + sample_t'($urandom_range(0, 3));
      MIX_FALLING: s = prev_sample - sample_t'($urandom_range(0, 3));
      default:     s = sample_t'($urandom);
    endcase
    prev_sample = s;
    return s;
  endfunction

  // Sends one sample of the running sequence; a new sequence length is drawn
  // around the current window, sometimes shorter than the window.
  task automatic push_next();
    sample_t s;
    if (seq_left == 0) begin
      if ($urandom_range(0, 5) == 0)
        seq_left = $urandom_range(1, (cur_win > 1) ? cur_win - 1 : 1);
      else
        seq_left = cur_win + $urandom_range(0, 2 * cur_win + 4);
      seq_mix = sample_mix_t'($urandom_range(0, 4));
    end
    s = pick_sample(seq_mix);
    seq_left--;
    push_word(s, seq_left == 0);
  endtask

  initial begin
    int phase;
    int budget;
    int n;
    logic [WIN_W-1:0] w;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Window size left at its reset value of one: every word is a result.
    push_word(sample_t'(32'h8000_0000), 1'b0);
    push_word(sample_t'(32'h7FFF_FFFF), 1'b0);
    push_word('0, 1'b0);
    push_word('1, 1'b1);
    settle();

    // Window of three with a tie, a new maximum and both extremes.
    write_window(3);
    push_word(5, 1'b0);
    push_word(5, 1'b0);
    push_word(3, 1'b0);
    push_word(7, 1'b0);
    push_word(sample_t'(32'h8000_0000), 1'b0);
    push_word(sample_t'(32'h7FFF_FFFF), 1'b0);
    push_word(1, 1'b1);
    settle();

    // A sequence that ends before its window fills gives no result.
    write_window(2);
    push_word(-9, 1'b1);
    settle();

    // Window shrinks in the middle of a sequence.
    write_window(4);
    push_word(9, 1'b0);
    push_word(-2, 1'b0);
    push_word(4, 1'b0);
    settle();
    write_window(2);
    push_word(1, 1'b0);
    push_word(0, 1'b1);
    settle();

    // A zero window acts as a window of one.
    write_window(0);
    push_word(-5, 1'b0);
    push_word(6, 1'b1);
    settle();

    gaps_on = 1'b1;
    phase = 0;
    while (sent < ITEM_TARGET) begin
      case (phase)
        0: w = WIN_W'(1);
        1: w = WIN_W'(MAX_WINDOW);
        2: w = WIN_W'(127);
        3: w = WIN_W'(65);
        4: w = WIN_W'(0);
        5: w = WIN_W'(2);
        default: w = ($urandom_range(0, 3) == 0) ? WIN_W'($urandom_range(0, 127))
                                                 : WIN_W'($urandom_range(1, 16));
      endcase
      write_window(w);
      // One phase runs against a long output hold-off with no sender gaps,
      // so the result queue fills and the input has to stall. With a window
      // of one every sample gives a word, so the queue is sure to fill.
      if (phase == 0) begin
        hold_reqs <= hold_reqs + 1;
        gaps_on = 1'b0;
      end else begin
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      budget = $urandom_range(60, 160);
      for (n = 0; n < budget && sent < ITEM_TARGET; n++) begin
        if (sent >= CALM_POINT) calm <= 1'b1;
        push_next();
      end
      settle();
      phase++;
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
